// ===== rtl/core/cdsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdsd_pkg
// Shared types, constants and constant-divider helpers for the countdown
// seven-segment display unit.
// ----------------------------------------------------------------------------
package cdsd_pkg;

	// count width and reset load value (504 hours in deciseconds)
	localparam int CNT_W = 29;
	localparam logic [CNT_W-1:0] RESET_START = 29'd18144000;

	// mode thresholds
	localparam logic [CNT_W-1:0] DECI_PER_HOUR = 29'd36000;
	localparam logic [CNT_W-1:0] DECI_PER_MIN  = 29'd600;

	// value shown when expired
	localparam logic [13:0] EXPIRED_VALUE = 14'd8888;

	// s1 .. s6 and the output register
	localparam int PIPE_DEPTH = 7;

	// request kinds
	localparam logic REQ_TICK   = 1'b0;
	localparam logic REQ_BUTTON = 1'b1;

	typedef enum logic [1:0] {
		DISP_HOURS,
		DISP_MINUTES,
		DISP_SECONDS,
		DISP_EXPIRED
	} mode_t;

	// raw segment patterns for digits 0 to 9
	localparam logic [7:0] SEG_TABLE [10] = '{
		8'h77, 8'h24, 8'h5d, 8'h6d, 8'h2e, 8'h6b, 8'h7b, 8'h25, 8'h7f, 8'h2f
	};

	// reciprocal constants, each exact over its input range
	localparam logic [28:0] RECIP10    = 29'd429496730;  // 2^32 / 10, 29-bit input
	localparam logic [26:0] RECIP60    = 27'd71582789;   // 2^32 / 60, 26-bit input
	localparam logic [13:0] RECIP_D10  = 14'd13108;      // 2^17 / 10, 14-bit input
	localparam logic [13:0] RECIP_D100 = 14'd10486;      // 2^20 / 100
	localparam logic [14:0] RECIP_D1K  = 15'd16778;      // 2^24 / 1000

	typedef struct packed {
		logic req_type;
		logic middle_pressed;
		logic up_pressed;
		logic down_pressed;
	} req_t;

	typedef struct packed {
		logic [7:0]       seg_ones;
		logic [7:0]       seg_tens;
		logic [7:0]       seg_hundreds;
		logic [7:0]       seg_thousands;
		logic [1:0]       display_mode;
		logic [CNT_W-1:0] remaining_out;
		logic             is_paused;
	} frame_t;

	// snapshot of state taken when a tick enters the pipeline
	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic             paused;
		logic             flash;
		logic             middle;
		logic             up;
		logic             down;
	} tick_t;

	// per-stage load enables from the pipeline control
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
		logic ld_s5;
		logic ld_s6;
		logic ld_out;
	} pipe_ctl_t;

	// count / 10
	function automatic logic [25:0] div10(input logic [28:0] x);
		logic [57:0] p;
		p = 58'(x) * 58'(RECIP10);
		return p[57:32];
	endfunction

	// x / 60 for x below 2^26
	function automatic logic [20:0] div60(input logic [25:0] x);
		logic [52:0] p;
		p = 53'(x) * 53'(RECIP60);
		return p[52:32];
	endfunction

	// shown-value digit dividers
	function automatic logic [10:0] dig_div10(input logic [13:0] x);
		logic [27:0] p;
		p = 28'(x) * 28'(RECIP_D10);
		return p[27:17];
	endfunction

	function automatic logic [7:0] dig_div100(input logic [13:0] x);
		logic [27:0] p;
		p = 28'(x) * 28'(RECIP_D100);
		return p[27:20];
	endfunction

	function automatic logic [4:0] dig_div1000(input logic [13:0] x);
		logic [28:0] p;
		p = 29'(x) * 29'(RECIP_D1K);
		return p[28:24];
	endfunction

	// segment byte, zero when blank or when the digit is above 9
	function automatic logic [7:0] seg_byte(input logic blank, input logic [3:0] d);
		if (blank || d > 4'd9) begin
			return 8'h00;
		end
		return {SEG_TABLE[d][6:0], 1'b0};
	endfunction

endpackage

// ===== rtl/core/countdown_seven_segment_display_unit.sv =====
`timescale 1ns / 1ps
// A tick request's frame passes through stage 1, stages 2 to 6 and the output register to out_data.
// Throughput: one request per cycle; every stage has its own load enable, so
// the pipeline fills its bubbles and only stalls when the output is held.
// Button requests are taken at the same rate and produce no frame.
// Reset: count loads 18144000, timer paused, flash counter 0, pipeline empty.
// ----------------------------------------------------------------------------
// countdown_seven_segment_display_unit
// Decisecond countdown with pause toggle and a four-digit seven-segment
// frame per tick. Holds the timer state and the pipeline valid chain.
// ----------------------------------------------------------------------------
module countdown_seven_segment_display_unit
	import cdsd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  req_t             in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output frame_t           out_data
);

	logic [CNT_W-1:0]      count_q;
	logic                  paused_q;
	logic [7:0]            flash_q;
	logic [CNT_W-1:0]      cnt_nxt;
	logic [7:0]            flash_nxt;
	logic [PIPE_DEPTH-1:0] vld_q;
	logic [PIPE_DEPTH-1:0] adv;
	logic                  req_acc, tick_acc, button_acc;
	tick_t                 tick_s1;
	pipe_ctl_t             ctl;

	// stage advance chain, back from the output register
	always_comb begin
		adv[PIPE_DEPTH-1] = !vld_q[PIPE_DEPTH-1] || out_ready;
		for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
	end

	assign in_ready   = adv[0];
	assign out_valid  = vld_q[PIPE_DEPTH-1];
	assign req_acc    = in_valid && in_ready;
	assign tick_acc   = req_acc && (in_data.req_type == REQ_TICK);
	assign button_acc = req_acc && (in_data.req_type == REQ_BUTTON);

	// next timer state for a tick
	assign cnt_nxt   = (count_q != '0 && !paused_q) ? (count_q - 1'b1) : count_q;
	assign flash_nxt = flash_q + 8'd1;

	// timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= RESET_START;
			paused_q <= 1'b1;
			flash_q  <= '0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_data;
			end else if (tick_acc) begin
				count_q <= cnt_nxt;
			end
			if (tick_acc) begin
				flash_q <= flash_nxt;
			end
			if (button_acc) begin
				paused_q <= !paused_q;
			end
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) vld_q[0] <= tick_acc;
			for (int i = 1; i < PIPE_DEPTH; i++) begin
				if (adv[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// stage 1: state snapshot for the display path
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			tick_s1.cnt    <= cnt_nxt;
			tick_s1.paused <= paused_q;
			tick_s1.flash  <= flash_nxt[2];
			tick_s1.middle <= in_data.middle_pressed;
			tick_s1.up     <= in_data.up_pressed;
			tick_s1.down   <= in_data.down_pressed;
		end
	end

	// stage loads for the datapath
	always_comb begin
		ctl.ld_s2  = adv[1];
		ctl.ld_s3  = adv[2];
		ctl.ld_s4  = adv[3];
		ctl.ld_s5  = adv[4];
		ctl.ld_s6  = adv[5];
		ctl.ld_out = adv[6];
	end

	cdsd_pipe u_pipe (
		.clk   (clk),
		.ctl   (ctl),
		.tick  (tick_s1),
		.frame (out_data)
	);

`ifndef SYNTHESIS
	// count only goes down unless reloaded
	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_we |=> count_q <= $past(count_q))
		else $error("count rose without a config write");

	// a paused tick leaves the count alone
	a_paused_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_acc && paused_q && !cfg_we) |=> count_q == $past(count_q))
		else $error("count moved while paused");

	// button request flips the pause flag
	a_pause_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		button_acc |=> paused_q != $past(paused_q))
		else $error("pause flag did not toggle");

	// expired frames only at zero count
	a_expired_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.display_mode == DISP_EXPIRED) |->
		out_data.remaining_out == '0)
		else $error("expired mode with nonzero count");

	// input back-pressure only when the pipeline is full and the output held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled with room in the pipeline");
`endif

endmodule

// ===== rtl/core/cdsd_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdsd_pipe
// Display datapath: splits the count into hours, minutes and seconds with
// reciprocal multipliers, picks the shown value, extracts four digits and
// encodes the segment bytes. At most one multiplier level per stage.
// ----------------------------------------------------------------------------
module cdsd_pipe
	import cdsd_pkg::*;
(
	input  logic      clk,
	input  pipe_ctl_t ctl,
	input  tick_t     tick,
	output frame_t    frame
);

	// fields that ride along every stage
	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic             paused;
		logic             flash;
		mode_t            mode;
	} carry_t;

	carry_t      c2_s2, c3_s3, c4_s4, c5_s5, c6_s6;
	mode_t       mode_c;
	logic [25:0] q10_s2, q10_s3;
	logic [19:0] q600_s3, q600_s4;
	logic [13:0] q36k_s4;
	logic [5:0]  sec_s4;
	logic [25:0] sec_full;
	logic [19:0] min_full;
	logic [13:0] val_c, val_s5, val_s6;
	logic [10:0] q1_s6;
	logic [7:0]  q2_s6;
	logic [4:0]  q3_s6;
	logic [20:0] q600_c, q36k_c;
	logic [13:0] d0_full;
	logic [10:0] d1_full;
	logic [7:0]  d2_full;
	logic [4:0]  d3_full;
	logic [3:0]  dig0, dig1, dig2, dig3;
	logic        flash_c;
	logic [3:0]  blank;

	// mode from count thresholds, then button overrides
	always_comb begin
		mode_c = DISP_HOURS;
		if (tick.cnt < DECI_PER_HOUR) mode_c = DISP_MINUTES;
		if (tick.cnt < DECI_PER_MIN) mode_c = DISP_SECONDS;
		if (tick.cnt == '0) mode_c = DISP_EXPIRED;
		if (tick.middle) mode_c = DISP_HOURS;
		if (tick.up) mode_c = DISP_MINUTES;
		if (tick.down) mode_c = DISP_SECONDS;
	end

	// stage 2: count / 10
	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			q10_s2 <= div10(tick.cnt);
			c2_s2  <= '{cnt: tick.cnt, paused: tick.paused, flash: tick.flash, mode: mode_c};
		end
	end

	// stage 3: count / 600
	assign q600_c = div60(q10_s2);

	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			q600_s3 <= q600_c[19:0];
			q10_s3  <= q10_s2;
			c3_s3   <= c2_s2;
		end
	end

	// stage 4: count / 36000 and seconds field
	assign q36k_c   = div60(26'(q600_s3));
	assign sec_full = q10_s3 - ((26'(q600_s3) << 6) - (26'(q600_s3) << 2));

	always_ff @(posedge clk) begin
		if (ctl.ld_s4) begin
			q36k_s4 <= q36k_c[13:0];
			q600_s4 <= q600_s3;
			sec_s4  <= sec_full[5:0];
			c4_s4   <= c3_s3;
		end
	end

	// stage 5: minutes field and shown value
	assign min_full = q600_s4 - ((20'(q36k_s4) << 6) - (20'(q36k_s4) << 2));

	always_comb begin
		case (c4_s4.mode)
			DISP_HOURS:   val_c = q36k_s4;
			DISP_MINUTES: val_c = 14'(min_full[5:0]);
			DISP_SECONDS: val_c = 14'(sec_s4);
			default:      val_c = EXPIRED_VALUE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s5) begin
			val_s5 <= val_c;
			c5_s5  <= c4_s4;
		end
	end

	// stage 6: decimal quotients of the shown value
	always_ff @(posedge clk) begin
		if (ctl.ld_s6) begin
			q1_s6  <= dig_div10(val_s5);
			q2_s6  <= dig_div100(val_s5);
			q3_s6  <= dig_div1000(val_s5);
			val_s6 <= val_s5;
			c6_s6  <= c5_s5;
		end
	end

	// digits, leading-zero blanking and flash
	assign d0_full = val_s6 - ((14'(q1_s6) << 3) + (14'(q1_s6) << 1));
	assign d1_full = q1_s6 - ((11'(q2_s6) << 3) + (11'(q2_s6) << 1));
	assign d2_full = q2_s6 - ((8'(q3_s6) << 3) + (8'(q3_s6) << 1));
	assign d3_full = (q3_s6 >= 5'd10) ? (q3_s6 - 5'd10) : q3_s6;
	assign dig0    = d0_full[3:0];
	assign dig1    = d1_full[3:0];
	assign dig2    = d2_full[3:0];
	assign dig3    = d3_full[3:0];
	assign flash_c = (c6_s6.paused || c6_s6.mode == DISP_EXPIRED) && c6_s6.flash;

	always_comb begin
		blank[0] = flash_c;
		blank[1] = flash_c || (q1_s6 == '0);
		blank[2] = flash_c || (q2_s6 == '0);
		blank[3] = flash_c || (q3_s6 == '0);
	end

	// output register
	always_ff @(posedge clk) begin
		if (ctl.ld_out) begin
			frame.seg_ones      <= seg_byte(blank[0], dig0);
			frame.seg_tens      <= seg_byte(blank[1], dig1);
			frame.seg_hundreds  <= seg_byte(blank[2], dig2);
			frame.seg_thousands <= seg_byte(blank[3], dig3);
			frame.display_mode  <= c6_s6.mode;
			frame.remaining_out <= c6_s6.cnt;
			frame.is_paused     <= c6_s6.paused;
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// countdown display unit testbench
// Runs the countdown unit through a set of start values, pause toggles and
// display overrides. Every accepted request updates a local timer model
// that builds the expected frame for each tick. Each frame from the unit is
// checked field by field against the oldest expected frame. Both sides idle
// at random, and the receiver holds off once for a long time.
// ----------------------------------------------------------------------------
module tb;
	import cdsd_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int LONG_HOLD  = 400;
	localparam int N_PHASES   = 10;
	localparam int PHASE_REQS = 183;
	localparam logic [CNT_W-1:0] CNT_MAX   = 29'h1FFFFFFF;
	localparam logic [CNT_W-1:0] LEGAL_MAX = 29'd359999999;

	// segment patterns for digits 0 to 9, before the shift
	localparam logic [7:0] GLYPH [10] = '{
		8'h77, 8'h24, 8'h5d, 8'h6d, 8'h2e, 8'h6b, 8'h7b, 8'h25, 8'h7f, 8'h2f
	};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CNT_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	req_t             in_data = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	frame_t           out_data;

	// timer model state
	logic [CNT_W-1:0] tmr_start;
	logic [CNT_W-1:0] tmr_count;
	logic             tmr_paused;
	logic [7:0]       tmr_flash;

	req_t        pending_reqs [$];
	frame_t      frame_q [$];
	bit          holding = 1'b0;
	int          burst_left = 1;
	int          gap_left = 0;
	bit          free_run = 1'b0;
	bit          hold_req = 1'b0;
	int          hold_left = 0;
	int          rx_left = 0;
	int          idle_cycles = 0;
	int unsigned n_fail = 0;
	int unsigned n_ticks = 0;
	int unsigned n_buttons = 0;
	int unsigned n_frames = 0;
	int unsigned n_expired = 0;
	int unsigned n_loads = 0;

	countdown_seven_segment_display_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	// advance the timer by one request; returns 1 when a frame is produced
	function automatic bit advance_timer(input req_t r, output frame_t f);
		mode_t       mode;
		int unsigned shown;
		logic [3:0]  dig [4];
		bit          blk [4];
		bit          flash;
		f = '0;
		if (r.req_type == REQ_BUTTON) begin
			tmr_paused = ~tmr_paused;
			return 1'b0;
		end
		if (tmr_count != '0 && !tmr_paused) begin
			tmr_count = tmr_count - 1'b1;
		end
		tmr_flash = tmr_flash + 8'd1;

		// mode from the count, then the held buttons, down strongest
		mode = DISP_HOURS;
		if (tmr_count < DECI_PER_HOUR) mode = DISP_MINUTES;
		if (tmr_count < DECI_PER_MIN) mode = DISP_SECONDS;
		if (tmr_count == '0) mode = DISP_EXPIRED;
		if (r.middle_pressed) mode = DISP_HOURS;
		if (r.up_pressed) mode = DISP_MINUTES;
		if (r.down_pressed) mode = DISP_SECONDS;

		case (mode)
			DISP_HOURS: begin
				shown = tmr_count / 36000;
			end
			DISP_MINUTES: begin
				shown = (tmr_count / 600) % 60;
			end
			DISP_SECONDS: begin
				shown = (tmr_count / 10) % 60;
			end
			default: begin
				shown = 32'(EXPIRED_VALUE);
			end
		endcase

		// digits from the ones upward, leading zeros blank
		for (int i = 0; i < 4; i++) begin
			blk[i] = (shown == 0);
			dig[i] = 4'(shown % 10);
			shown = shown / 10;
		end
		blk[0] = 1'b0;

		flash = (tmr_paused || mode == DISP_EXPIRED) && tmr_flash[2];
		f.seg_ones      = (blk[0] || flash) ? 8'h00 : {GLYPH[dig[0]][6:0], 1'b0};
		f.seg_tens      = (blk[1] || flash) ? 8'h00 : {GLYPH[dig[1]][6:0], 1'b0};
		f.seg_hundreds  = (blk[2] || flash) ? 8'h00 : {GLYPH[dig[2]][6:0], 1'b0};
		f.seg_thousands = (blk[3] || flash) ? 8'h00 : {GLYPH[dig[3]][6:0], 1'b0};
		f.display_mode  = mode;
		f.remaining_out = tmr_count;
		f.is_paused     = tmr_paused;
		return 1'b1;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			n_fail++;
		end
	endfunction

	// request driver, bursts with random gaps
	always @(posedge clk) begin
		frame_t f;
		if (in_valid && in_ready) begin
			holding = 1'b0;
			if (in_data.req_type == REQ_BUTTON) n_buttons++;
			else n_ticks++;
			if (advance_timer(in_data, f)) frame_q.push_back(f);
		end
		if (holding) begin
			// request still on offer
		end else if (arst_n && gap_left == 0 && pending_reqs.size() != 0) begin
			in_data <= pending_reqs.pop_front();
			in_valid <= 1'b1;
			holding = 1'b1;
			if (burst_left > 1) begin
				burst_left--;
			end else begin
				burst_left = free_run ? 1000 : $urandom_range(1, 24);
				gap_left = (free_run || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			end
		end else begin
			in_valid <= 1'b0;
			if (gap_left > 0) gap_left--;
		end
	end

	// receiver stall pattern, with a single long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = LONG_HOLD;
			out_ready <= 1'b0;
		end else if (free_run) begin
			out_ready <= 1'b1;
		end else if (rx_left > 0) begin
			rx_left--;
		end else if (out_ready) begin
			out_ready <= 1'b0;
			rx_left = $urandom_range(0, 5);
		end else begin
			out_ready <= 1'b1;
			rx_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(0, 20);
		end
	end

	// frame checker
	always @(posedge clk) begin
		frame_t want;
		if (arst_n && out_valid && out_ready) begin
			if (frame_q.size() == 0) begin
				$error("frame with no tick pending: %h", out_data);
				n_fail++;
			end else begin
				want = frame_q.pop_front();
				n_frames++;
				if (want.display_mode == DISP_EXPIRED) n_expired++;
				check_field("seg_ones", 32'(want.seg_ones), 32'(out_data.seg_ones));
				check_field("seg_tens", 32'(want.seg_tens), 32'(out_data.seg_tens));
				check_field("seg_hundreds", 32'(want.seg_hundreds),
					32'(out_data.seg_hundreds));
				check_field("seg_thousands", 32'(want.seg_thousands),
					32'(out_data.seg_thousands));
				check_field("display_mode", 32'(want.display_mode),
					32'(out_data.display_mode));
				check_field("remaining_out", 32'(want.remaining_out),
					32'(out_data.remaining_out));
				check_field("is_paused", 32'(want.is_paused), 32'(out_data.is_paused));
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: %0d frames still pending", frame_q.size());
			$display("tb NOT OK");
			$finish;
		end
	end

	task automatic push_req(input logic kind, input bit m, input bit u, input bit d);
		req_t r;
		r.req_type = kind;
		r.middle_pressed = m;
		r.up_pressed = u;
		r.down_pressed = d;
		pending_reqs.push_back(r);
	endtask

	// wait until every request is taken and every frame has come out
	task automatic settle();
		while (pending_reqs.size() != 0 || holding || frame_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (PIPE_DEPTH + 4) @(posedge clk);
	endtask

	task automatic load_start(input logic [CNT_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tmr_start = v;
		tmr_count = v;
		n_loads++;
	endtask

	// mostly ticks, buttons held at random, a few pause toggles
	task automatic queue_random(input int n);
		repeat (n) begin
			push_req(($urandom_range(0, 99) < 8) ? REQ_BUTTON : REQ_TICK,
				$urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
				$urandom_range(0, 3) == 0);
		end
	endtask

	initial begin
		logic [CNT_W-1:0] sv;
		tmr_start = RESET_START;
		tmr_count = RESET_START;
		tmr_paused = 1'b1;
		tmr_flash = 8'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset start value while paused: flashing and every override
		push_req(REQ_TICK, 0, 0, 0);
		push_req(REQ_TICK, 1, 0, 0);
		push_req(REQ_TICK, 0, 1, 0);
		push_req(REQ_TICK, 0, 0, 1);
		push_req(REQ_TICK, 1, 1, 1);
		push_req(REQ_BUTTON, 0, 0, 0);
		push_req(REQ_TICK, 0, 0, 0);
		push_req(REQ_TICK, 1, 1, 0);
		settle();

		// count reaches zero, overrides at zero, expired while paused
		load_start(29'd1);
		push_req(REQ_TICK, 0, 0, 0);
		push_req(REQ_TICK, 0, 0, 1);
		push_req(REQ_TICK, 0, 1, 0);
		push_req(REQ_TICK, 1, 0, 0);
		push_req(REQ_BUTTON, 1, 1, 1);
		push_req(REQ_TICK, 0, 0, 0);
		push_req(REQ_TICK, 0, 0, 1);
		settle();

		// oversized start value, hours wider than four digits
		load_start(CNT_MAX);
		push_req(REQ_BUTTON, 0, 0, 0);
		push_req(REQ_TICK, 1, 0, 0);
		push_req(REQ_TICK, 0, 0, 0);
		settle();

		// crossing into minutes, then into seconds
		load_start(29'd36001);
		push_req(REQ_TICK, 0, 0, 0);
		push_req(REQ_TICK, 0, 0, 0);
		settle();
		load_start(29'd601);
		push_req(REQ_TICK, 0, 0, 0);
		push_req(REQ_TICK, 0, 0, 0);
		settle();

		// random phases, each from its own start value
		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: sv = '0;
				1: sv = 29'd1;
				2: sv = LEGAL_MAX;
				3: sv = CNT_MAX;
				4: sv = CNT_W'(36000 + $urandom_range(0, 40));
				5: sv = CNT_W'(600 + $urandom_range(0, 60));
				6: sv = RESET_START;
				7: sv = CNT_W'($urandom_range(0, 359999999));
				default: sv = CNT_W'($urandom_range(0, 150));
			endcase
			free_run = (ph == 6);
			load_start(sv);
			// mostly start from a running timer so the count moves
			if (tmr_paused && $urandom_range(0, 9) < 8) push_req(REQ_BUTTON, 0, 0, 0);
			queue_random(PHASE_REQS);
			if (ph == 4) hold_req = 1'b1;
			settle();
		end

		$display("covered %0d ticks and %0d pause toggles over %0d start loads",
			n_ticks, n_buttons, n_loads);
		$display("%0d frames checked, %0d of them expired", n_frames, n_expired);
		if (n_fail == 0 && frame_q.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/cdsd_pkg.sv
rtl/core/cdsd_pipe.sv
rtl/core/countdown_seven_segment_display_unit.sv
tb/tb.sv
